>>> rtl/tes_pkg.sv
// Shared types and constants for the tripled entry pair search block.
`default_nettype none
package tes_pkg;

    localparam int CODE_W    = 32;
    localparam int STOCK_W   = 16;
    localparam int POS_W     = 10;
    localparam int TOTAL_W   = 18;
    localparam int MIN_ITEMS = 3;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [STOCK_W-1:0] stock;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Search launch from the load side.
    typedef struct packed {
        logic go;
        logic err;
    } cmd_t;

    typedef struct packed {
        logic [POS_W-1:0]   first_pos;
        logic [POS_W-1:0]   second_pos;
        logic [POS_W-1:0]   third_pos;
        logic [CODE_W-1:0]  code;
        logic [TOTAL_W-1:0] total;
        logic               err;
    } res_t;

endpackage
`default_nettype wire

>>> rtl/tes_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/tes_search.sv
// Pair search sequencer: binary search over pair indices, then gathers the tripled run.
`default_nettype none
module tes_search
    import tes_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire cmd_t                                cmd,
    input  wire logic [$clog2(STORE_DEPTH+1)-1:0]    item_count,
    output logic      [$clog2(STORE_DEPTH)-1:0]      rd_addr,
    input  wire entry_t                              rd_entry,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output res_t                                     res
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_TEST, S_RDB, S_CAPA, S_CMP, S_F0, S_F1, S_F2, S_F3, S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [AW-1:0]       low_reg, low_next;
    logic [AW-1:0]       high_reg, high_next;
    logic [AW-1:0]       raddr_reg, raddr_next;
    logic [AW-1:0]       third_reg, third_next;
    logic [AW-1:0]       mid_reg, mid_next;
    logic [CODE_W-1:0]   code_a_reg, code_a_next;
    res_t                res_reg, res_next;

    logic [AW-1:0]       span;
    logic [AW:0]         mid_sum;
    logic [AW-1:0]       mid;
    logic [AW:0]         dbl;
    logic [AW:0]         n_ext;
    logic [AW-1:0]       third_sel;
    logic [AW-1:0]       p_sel;
    logic [TOTAL_W-1:0]  acc_sum;

    assign span      = high_reg - low_reg;
    assign mid_sum   = {1'b0, low_reg} + {1'b0, high_reg};
    assign mid       = mid_sum[AW:1];
    assign dbl       = {high_reg, 1'b0};
    assign n_ext     = (AW+1)'(n_reg);
    // Clamp the third position to the last stored entry on a malformed run.
    assign third_sel = (dbl >= n_ext) ? AW'(n_ext - 1'b1) : dbl[AW-1:0];
    assign p_sel     = third_sel - AW'(2);
    // Shared accumulator that adds the second and third stock counts to the total.
    assign acc_sum   = res_reg.total + TOTAL_W'(rd_entry.stock);

    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        raddr_next  = raddr_reg;
        third_next  = third_reg;
        mid_next    = mid_reg;
        code_a_next = code_a_reg;
        res_next    = res_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.go) begin
                    res_next = '0;
                    if (cmd.err) begin
                        res_next.err = 1'b1;
                        state_next   = S_DONE;
                    end else begin
                        n_next     = item_count;
                        low_next   = '0;
                        high_next  = AW'(item_count >> 1);
                        state_next = S_TEST;
                    end
                end
            end
            S_TEST: begin
                if (span > AW'(1)) begin
                    mid_next   = mid;
                    raddr_next = {mid[AW-2:0], 1'b0};
                    state_next = S_RDB;
                end else begin
                    third_next = third_sel;
                    raddr_next = p_sel;
                    state_next = S_F0;
                end
            end
            S_RDB: begin
                raddr_next = raddr_reg | AW'(1);
                state_next = S_CAPA;
            end
            S_CAPA: begin
                code_a_next = rd_entry.code;
                state_next  = S_CMP;
            end
            S_CMP: begin
                if (code_a_reg == rd_entry.code) begin
                    low_next = mid_reg;
                end else begin
                    high_next = mid_reg;
                end
                state_next = S_TEST;
            end
            S_F0: begin
                res_next.first_pos  = POS_W'(raddr_reg);
                res_next.second_pos = POS_W'(raddr_reg + AW'(1));
                res_next.third_pos  = POS_W'(third_reg);
                raddr_next          = raddr_reg + AW'(1);
                state_next          = S_F1;
            end
            S_F1: begin
                res_next.code  = rd_entry.code;
                res_next.total = TOTAL_W'(rd_entry.stock);
                raddr_next     = third_reg;
                state_next     = S_F2;
            end
            S_F2: begin
                res_next.total = acc_sum;
                state_next     = S_F3;
            end
            S_F3: begin
                res_next.total = acc_sum;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        n_reg      <= n_next;
        low_reg    <= low_next;
        high_reg   <= high_next;
        raddr_reg  <= raddr_next;
        third_reg  <= third_next;
        mid_reg    <= mid_next;
        code_a_reg <= code_a_next;
        res_reg    <= res_next;
    end

    assign rd_addr   = raddr_reg;
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule
`default_nettype wire

>>> rtl/tripled_entry_pair_search.sv
// Tripled entry pair search: top level with item loading and result register.
//
// Input beats (s_valid/s_ready) carry a product code, a stock count and a
// last-item flag. Each beat is written to the next free entry of one entry
// RAM; s_ready stays high while loading. Beats beyond
// STORE_DEPTH are dropped and flag an overflow for the run.
// The beat with s_last_item high starts the search and drops s_ready until
// the result has moved into the output register. The search halves the pair
// range once per iteration; each iteration reads both entries of the middle
// pair through the single RAM read port and compares their codes. It then
// reads the three run entries, sums their stocks and hands the result over.
// Too few items or an overflow give a result with m_count_error high and all
// other fields zero, without a search.
// One result beat (m_valid/m_ready) per run. A stalled receiver holds the
// result in the output register; the next run may load meanwhile, and its
// result waits in the sequencer until the register is free.
// Synchronous active-low reset empties the store count, the overflow, busy and
// valid flags and the sequencer; output data and RAM contents are not cleared.
`default_nettype none
module tripled_entry_pair_search
    import tes_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [CODE_W-1:0]  s_product_code,
    input  wire logic [STOCK_W-1:0] s_stock_count,
    input  wire logic               s_last_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [POS_W-1:0]        m_first_position,
    output logic [POS_W-1:0]        m_second_position,
    output logic [POS_W-1:0]        m_third_position,
    output logic [CODE_W-1:0]       m_tripled_code,
    output logic [TOTAL_W-1:0]      m_stock_total,
    output logic                    m_count_error
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    logic          count_reg_en;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          busy_reg, busy_next;
    logic          m_valid_reg, m_valid_next;
    res_t          out_reg, out_next;

    logic          accept;
    logic          room;
    logic [CW-1:0] n_now;
    cmd_t          cmd;
    entry_t        wr_entry;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;
    logic [AW-1:0] rd_addr;
    logic          res_valid;
    logic          res_ready;
    res_t          res;

    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign room    = (count_reg < CW'(STORE_DEPTH));
    assign n_now   = count_reg + CW'(room);
    assign count_reg_en = accept && room;

    assign wr_entry.code  = s_product_code;
    assign wr_entry.stock = s_stock_count;
    assign wr_data        = wr_entry;

    assign cmd.go  = accept && s_last_item;
    assign cmd.err = (n_now < CW'(MIN_ITEMS)) || ovf_reg || !room;

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (accept) begin
            if (s_last_item) begin
                // Close the run and start a fresh one.
                count_next = '0;
                ovf_next   = 1'b0;
                busy_next  = 1'b1;
            end else if (room) begin
                count_next = n_now;
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
            busy_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    tes_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (count_reg_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    tes_search #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_search (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .item_count (n_now),
        .rd_addr    (rd_addr),
        .rd_entry   (rd_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign m_valid           = m_valid_reg;
    assign m_first_position  = out_reg.first_pos;
    assign m_second_position = out_reg.second_pos;
    assign m_third_position  = out_reg.third_pos;
    assign m_tripled_code    = out_reg.code;
    assign m_stock_total     = out_reg.total;
    assign m_count_error     = out_reg.err;

endmodule
`default_nettype wire

>>> test/tripled_entry_pair_search_tb.sv
// Self-checking testbench for the tripled entry pair search block.
module tripled_entry_pair_search_tb;
    import tes_pkg::*;

    localparam int DEPTH = 1024;
    localparam int RANDOM_ITEMS = 1050;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [CODE_W-1:0]  code;
        logic [STOCK_W-1:0] stock;
        logic               last;
    } item_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [CODE_W-1:0]   s_product_code = '0;
    logic [STOCK_W-1:0]  s_stock_count = '0;
    logic                s_last_item = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [POS_W-1:0]    m_first_position;
    logic [POS_W-1:0]    m_second_position;
    logic [POS_W-1:0]    m_third_position;
    logic [CODE_W-1:0]   m_tripled_code;
    logic [TOTAL_W-1:0]  m_stock_total;
    logic                m_count_error;

    item_t       pending_items[$];
    res_t        expected_results[$];
    int unsigned mismatches = 0;

    // shadow copy of the block's store
    logic [CODE_W-1:0]  code_mem[DEPTH];
    logic [STOCK_W-1:0] stock_mem[DEPTH];
    int unsigned        loaded = 0;
    bit                 store_overflow = 1'b0;

    bit          in_taken = 1'b0;
    int unsigned in_gap = 0;
    int unsigned in_quiet = 0;
    int unsigned out_stall = 0;
    int unsigned out_quiet = 0;

    tripled_entry_pair_search #(
        .STORE_DEPTH(DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_product_code(s_product_code),
        .s_stock_count(s_stock_count),
        .s_last_item(s_last_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_first_position(m_first_position),
        .m_second_position(m_second_position),
        .m_third_position(m_third_position),
        .m_tripled_code(m_tripled_code),
        .m_stock_total(m_stock_total),
        .m_count_error(m_count_error)
    );

    always #5 aclk = ~aclk;

    function automatic void predict_search_result(logic [CODE_W-1:0] code,
                                                  logic [STOCK_W-1:0] stock, logic last);
        int unsigned n, lo, hi, mid, third, p;
        logic [TOTAL_W-1:0] sum;
        res_t r;
        if (loaded < DEPTH) begin
            code_mem[loaded] = code;
            stock_mem[loaded] = stock;
            loaded++;
        end else begin
            store_overflow = 1'b1;
        end
        if (!last) return;
        r = '0;
        n = loaded;
        if (n < MIN_ITEMS || store_overflow) begin
            r.err = 1'b1;
        end else begin
            lo = 0;
            hi = n / 2;
            // narrow down to the first pair whose two entries disagree
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (2 * mid + 1 < n && 2 * mid + 1 < DEPTH
                        && code_mem[2 * mid] == code_mem[2 * mid + 1])
                    lo = mid;
                else
                    hi = mid;
            end
            third = 2 * hi;
            if (third >= n) third = n - 1;
            p = third - 2;
            sum = TOTAL_W'(stock_mem[p]) + TOTAL_W'(stock_mem[p + 1])
                + TOTAL_W'(stock_mem[third]);
            r.first_pos = POS_W'(p);
            r.second_pos = POS_W'(p + 1);
            r.third_pos = POS_W'(third);
            r.code = code_mem[p];
            r.total = sum;
        end
        expected_results.push_back(r);
        loaded = 0;
        store_overflow = 1'b0;
    endfunction

    function automatic void check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [CODE_W-1:0] pick_code(bit narrow);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (narrow) return $urandom_range(0, 3);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom();
    endfunction

    function automatic logic [STOCK_W-1:0] pick_stock();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return STOCK_W'($urandom_range(0, 65535));
    endfunction

    function automatic void push_beat(logic [CODE_W-1:0] code, logic [STOCK_W-1:0] stock,
                                      logic last);
        item_t it;
        it.code = code;
        it.stock = stock;
        it.last = last;
        pending_items.push_back(it);
    endfunction

    // pairs of equal codes, the pair at triple_at repeated three times;
    // triple_at < 0 picks one at random, triple_at >= pairs leaves an even run
    function automatic int unsigned add_tripled_run(int pairs, int triple_at, bit narrow);
        int unsigned n, idx;
        logic [CODE_W-1:0] c;
        if (triple_at < 0) triple_at = $urandom_range(0, pairs - 1);
        n = 2 * pairs + ((triple_at < pairs) ? 1 : 0);
        idx = 0;
        for (int i = 0; i < pairs; i++) begin
            c = pick_code(narrow);
            repeat ((i == triple_at) ? 3 : 2) begin
                push_beat(c, pick_stock(), idx == n - 1);
                idx++;
            end
        end
        return n;
    endfunction

    function automatic int unsigned add_loose_run(int unsigned len, bit narrow);
        for (int unsigned i = 0; i < len; i++)
            push_beat(pick_code(narrow), pick_stock(), i == len - 1);
        return len;
    endfunction

    function automatic int unsigned add_random_run();
        int unsigned r, pairs;
        r = $urandom_range(0, 99);
        pairs = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 100);
        if (r < 70) return add_tripled_run(pairs, -1, 1'b0);
        if (r < 78) return add_tripled_run(pairs, -1, 1'b1);
        if (r < 86) return add_loose_run($urandom_range(1, 12), $urandom_range(0, 1) == 1);
        if (r < 93) return add_tripled_run(pairs, pairs, 1'b0);
        return add_loose_run($urandom_range(1, 2), 1'b0);
    endfunction

    // input driver: hold the beat until taken, then gap or present the next one
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_product_code <= pending_items[0].code;
                    s_stock_count <= pending_items[0].stock;
                    s_last_item <= pending_items[0].last;
                    s_valid <= 1'b1;
                    void'(pending_items.pop_front());
                    if (in_quiet > 0) begin
                        in_quiet--;
                        in_gap = 0;
                    end else begin
                        in_gap = pick_gap();
                        if ($urandom_range(0, 49) == 0) in_quiet = $urandom_range(30, 120);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver stalls
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_stall > 0) begin
                out_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (out_quiet > 0) begin
                    out_quiet--;
                end else if ($urandom_range(0, 99) < 30) begin
                    out_stall = pick_gap();
                    if ($urandom_range(0, 49) == 0) out_quiet = $urandom_range(30, 120);
                end
            end
        end
    end

    always @(posedge aclk) begin
        res_t want;
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken)
            predict_search_result(s_product_code, s_stock_count, s_last_item);
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no expectation pending");
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("first_position", 64'(m_first_position), 64'(want.first_pos));
                check_field("second_position", 64'(m_second_position),
                            64'(want.second_pos));
                check_field("third_position", 64'(m_third_position), 64'(want.third_pos));
                check_field("tripled_code", 64'(m_tripled_code), 64'(want.code));
                check_field("stock_total", 64'(m_stock_total), 64'(want.total));
                check_field("count_error", 64'(m_count_error), 64'(want.err));
            end
        end
    end

    initial begin
        int unsigned random_items;
        random_items = 0;

        // too few items: one, then two
        push_beat('1, '1, 1'b1);
        push_beat('0, '0, 1'b0);
        push_beat('1, '1, 1'b1);
        // shortest run at both extremes, largest stock total
        repeat (2) push_beat('1, '1, 1'b0);
        push_beat('1, '1, 1'b1);
        repeat (2) push_beat('0, '0, 1'b0);
        push_beat('0, '0, 1'b1);
        // tripled run first and last, then an even run that forces the clamp
        void'(add_tripled_run(2, 0, 1'b0));
        void'(add_tripled_run(2, 1, 1'b0));
        void'(add_tripled_run(2, 2, 1'b0));

        while (random_items < RANDOM_ITEMS)
            random_items += add_random_run();

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
